// ===== hdl/h2d_pkg.sv =====
// Shared types, constants and helpers for the 2-D histogram binner.
package h2d_pkg;

   localparam int MAX_BINS    = 4096;
   localparam int COUNT_WIDTH = 32;
   localparam int BIN_AW      = $clog2(MAX_BINS);
   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // operation codes
   localparam logic [1:0] OP_ACCUM = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // register indexes
   localparam logic [2:0] REG_X_ORIGIN = 3'd0;
   localparam logic [2:0] REG_Y_ORIGIN = 3'd1;
   localparam logic [2:0] REG_X_SCALE  = 3'd2;
   localparam logic [2:0] REG_Y_SCALE  = 3'd3;
   localparam logic [2:0] REG_BINS_X   = 3'd4;
   localparam logic [2:0] REG_BINS_Y   = 3'd5;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic               point_defined;
      logic [11:0]        bin_select;
   } h2d_req_type;

   typedef struct packed {
      logic [11:0] bin_index;
      logic        in_range;
      logic [31:0] bin_count;
      logic [31:0] peak_count;
      logic [31:0] outside_count;
   } h2d_rsp_type;

   typedef struct packed {
      logic signed [31:0] x_origin;
      logic signed [31:0] y_origin;
      logic [31:0]        x_scale;
      logic [31:0]        y_scale;
      logic [12:0]        bins_x;
      logic [12:0]        bins_y;
   } h2d_cfg_type;

   // classified operation handed from front to back
   typedef struct packed {
      logic [1:0]  op;
      logic        hit;       // point in grid / selected bin in grid
      logic        in_store;  // index addresses a real bin
      logic [11:0] index;
   } h2d_task_type;

   // queue to back-end handshake
   typedef struct packed {
      logic         valid;
      h2d_task_type data;
   } h2d_head_type;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
      sat_inc = (v == COUNT_MAX) ? v : v + COUNT_WIDTH'(1);
   endfunction

endpackage

// ===== hdl/h2d_front.sv =====
// Front end: bins each point through a four-stage pipeline and classifies the word.
module h2d_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  h2d_pkg::h2d_req_type req_word,
   input  h2d_pkg::h2d_cfg_type cfg,
   output logic                 push,
   output h2d_pkg::h2d_task_type push_data,
   output logic [2:0]           inflight
);
   import h2d_pkg::*;

   // stage 0: captured word
   logic        s0_valid_ff;
   h2d_req_type s0_word_ff;

   // stage 1: offsets from origin
   logic               s1_valid_ff;
   logic [1:0]         s1_op_ff;
   logic               s1_def_ff;
   logic signed [32:0] s1_dx_ff, s1_dy_ff;
   logic signed [32:0] s1_dx_in, s1_dy_in;
   logic [11:0]        s1_sel_ff;

   // stage 2: scaled bin coordinates
   logic        s2_valid_ff;
   logic [1:0]  s2_op_ff;
   logic        s2_def_ff;
   logic        s2_fail_ff, s2_fail_in;
   logic [31:0] s2_bx_ff, s2_by_ff;
   logic [63:0] prod_x, prod_y;
   logic [25:0] s2_grid_ff;
   logic [11:0] s2_sel_ff;

   // stage 3: grid checks, row offset
   logic        s3_valid_ff;
   logic [1:0]  s3_op_ff;
   logic        s3_ok_ff, s3_ok_in;
   logic [25:0] s3_row_ff;
   logic [12:0] s3_bx_ff;
   logic        s3_rdhit_ff, s3_instore_ff;
   logic [11:0] s3_sel_ff;

   logic [26:0] flat;
   logic        acc_ok;

   always_comb begin
      s1_dx_in = {s0_word_ff.point_x[31], s0_word_ff.point_x} -
                 {cfg.x_origin[31], cfg.x_origin};
      s1_dy_in = {s0_word_ff.point_y[31], s0_word_ff.point_y} -
                 {cfg.y_origin[31], cfg.y_origin};
      // a nonnegative offset fits 32 bits unsigned
      prod_x     = 64'(s1_dx_ff[31:0]) * 64'(cfg.x_scale);
      prod_y     = 64'(s1_dy_ff[31:0]) * 64'(cfg.y_scale);
      s2_fail_in = (s1_dx_ff[32] && (cfg.x_scale != 32'd0)) ||
                   (s1_dy_ff[32] && (cfg.y_scale != 32'd0));
      s3_ok_in   = s2_def_ff && !s2_fail_ff &&
                   (s2_bx_ff < 32'(cfg.bins_x)) && (s2_by_ff < 32'(cfg.bins_y));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= accept;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      if (accept) s0_word_ff <= req_word;

      s1_op_ff  <= s0_word_ff.operation;
      s1_def_ff <= s0_word_ff.point_defined;
      s1_dx_ff  <= s1_dx_in;
      s1_dy_ff  <= s1_dy_in;
      s1_sel_ff <= s0_word_ff.bin_select;

      s2_op_ff   <= s1_op_ff;
      s2_def_ff  <= s1_def_ff;
      s2_fail_ff <= s2_fail_in;
      s2_bx_ff   <= prod_x[63:32];
      s2_by_ff   <= prod_y[63:32];
      s2_grid_ff <= 26'(cfg.bins_x) * 26'(cfg.bins_y);
      s2_sel_ff  <= s1_sel_ff;

      s3_op_ff      <= s2_op_ff;
      s3_ok_ff      <= s3_ok_in;
      s3_row_ff     <= 26'(s2_by_ff[12:0]) * 26'(cfg.bins_x);
      s3_bx_ff      <= s2_bx_ff[12:0];
      s3_rdhit_ff   <= (26'(s2_sel_ff) < s2_grid_ff) && (32'(s2_sel_ff) < 32'(MAX_BINS));
      s3_instore_ff <= 32'(s2_sel_ff) < 32'(MAX_BINS);
      s3_sel_ff     <= s2_sel_ff;
   end

   always_comb begin
      flat      = 27'(s3_row_ff) + 27'(s3_bx_ff);
      acc_ok    = s3_ok_ff && (32'(flat) < 32'(MAX_BINS));
      push      = s3_valid_ff;
      push_data = '0;
      push_data.op = s3_op_ff;
      unique case (s3_op_ff)
         OP_ACCUM: begin
            push_data.hit      = acc_ok;
            push_data.in_store = acc_ok;
            push_data.index    = acc_ok ? flat[11:0] : 12'd0;
         end
         OP_READ: begin
            push_data.hit      = s3_rdhit_ff;
            push_data.in_store = s3_instore_ff;
            push_data.index    = s3_sel_ff;
         end
         default: begin
            push_data.hit = 1'b0;
         end
      endcase
      inflight = 3'(s0_valid_ff) + 3'(s1_valid_ff) + 3'(s2_valid_ff) + 3'(s3_valid_ff);
   end

endmodule

// ===== hdl/h2d_queue.sv =====
// Short FIFO of classified words between front and back end.
module h2d_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  h2d_pkg::h2d_task_type push_data,
   input  logic                  pop,
   output h2d_pkg::h2d_head_type head,
   output logic [h2d_pkg::QUEUE_AW:0] count
);
   import h2d_pkg::*;

   h2d_task_type           slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]      count_ff, count_in;

   always_comb begin
      count_in = count_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
      head.valid = count_ff != '0;
      head.data  = slot_ff[rd_ptr_ff];
      count      = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + QUEUE_AW'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(1);
         count_ff <= count_in;
      end
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ===== hdl/h2d_back.sv =====
// Back end: bin count memory with read-modify-write, peak and outside counters, clear sweep.
module h2d_back (
   input  logic                  clock,
   input  logic                  reset,
   input  h2d_pkg::h2d_head_type head,
   output logic                  pop,
   output logic                  sweeping,
   output logic                  rsp_valid,
   output h2d_pkg::h2d_rsp_type  rsp_word
);
   import h2d_pkg::*;

   logic [COUNT_WIDTH-1:0] mem [MAX_BINS];
   logic [COUNT_WIDTH-1:0] rd_data_ff;

   logic         a_valid_ff, b_valid_ff;
   h2d_task_type a_task_ff, b_task_ff;

   logic                   last_wr_valid_ff, last_wr_valid_in;
   logic [BIN_AW-1:0]      last_wr_addr_ff;
   logic [COUNT_WIDTH-1:0] last_wr_data_ff;

   logic                   sweep_ff;
   logic [BIN_AW-1:0]      sweep_addr_ff;

   logic [COUNT_WIDTH-1:0] peak_ff, peak_in, outside_ff, outside_in;
   logic [COUNT_WIDTH-1:0] cur, cnt_new;
   logic [BIN_AW-1:0]      b_addr;
   logic                   acc_write, start_sweep;

   logic                   wr_en;
   logic [BIN_AW-1:0]      wr_addr;
   logic [COUNT_WIDTH-1:0] wr_data;

   logic         rsp_valid_ff;
   h2d_rsp_type  rsp_word_ff, rsp_word_in;

   // hold pops while a clear is in flight or the sweep runs
   assign pop = head.valid && !sweep_ff &&
                !(a_valid_ff && (a_task_ff.op == OP_CLEAR)) &&
                !(b_valid_ff && (b_task_ff.op == OP_CLEAR));
   assign sweeping  = sweep_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      b_addr  = BIN_AW'(b_task_ff.index);
      // one-deep forward covers the write that raced this word's read
      cur     = (last_wr_valid_ff && (last_wr_addr_ff == b_addr)) ?
                last_wr_data_ff : rd_data_ff;
      cnt_new = sat_inc(cur);
      acc_write   = 1'b0;
      start_sweep = 1'b0;
      peak_in     = peak_ff;
      outside_in  = outside_ff;
      rsp_word_in = '0;
      if (b_valid_ff) begin
         unique case (b_task_ff.op)
            OP_ACCUM: begin
               if (b_task_ff.hit) begin
                  acc_write = 1'b1;
                  if (cnt_new > peak_ff) peak_in = cnt_new;
                  rsp_word_in.bin_index = b_task_ff.index;
                  rsp_word_in.in_range  = 1'b1;
                  rsp_word_in.bin_count = 32'(cnt_new);
               end else begin
                  outside_in = sat_inc(outside_ff);
               end
            end
            OP_READ: begin
               rsp_word_in.bin_index = b_task_ff.index;
               rsp_word_in.in_range  = b_task_ff.hit;
               rsp_word_in.bin_count = b_task_ff.in_store ? 32'(cur) : 32'd0;
            end
            OP_CLEAR: begin
               start_sweep = 1'b1;
               peak_in     = '0;
               outside_in  = '0;
            end
            default: begin
               rsp_word_in.in_range = 1'b0;
            end
         endcase
      end
      rsp_word_in.peak_count    = 32'(peak_in);
      rsp_word_in.outside_count = 32'(outside_in);

      last_wr_valid_in = acc_write;
      wr_en   = sweep_ff || acc_write;
      wr_addr = sweep_ff ? sweep_addr_ff : b_addr;
      wr_data = sweep_ff ? '0 : cnt_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff       <= 1'b0;
         b_valid_ff       <= 1'b0;
         last_wr_valid_ff <= 1'b0;
         sweep_ff         <= 1'b1;
         sweep_addr_ff    <= '0;
         peak_ff          <= '0;
         outside_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         a_valid_ff       <= pop;
         b_valid_ff       <= a_valid_ff;
         last_wr_valid_ff <= last_wr_valid_in;
         peak_ff          <= peak_in;
         outside_ff       <= outside_in;
         rsp_valid_ff     <= b_valid_ff;
         if (start_sweep) begin
            sweep_ff      <= 1'b1;
            sweep_addr_ff <= '0;
         end else if (sweep_ff) begin
            if (sweep_addr_ff == BIN_AW'(MAX_BINS - 1)) sweep_ff <= 1'b0;
            sweep_addr_ff <= sweep_addr_ff + BIN_AW'(1);
         end
      end
      if (pop) a_task_ff <= head.data;
      b_task_ff       <= a_task_ff;
      last_wr_addr_ff <= b_addr;
      last_wr_data_ff <= cnt_new;
      rsp_word_ff     <= rsp_word_in;
   end

   // bin count memory
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[BIN_AW'(a_task_ff.index)];
   end

endmodule

// ===== hdl/histogram_2d_binner.sv =====
// Top level of the 2-D histogram binner: registers, front end, queue, back end.
//
// A word is taken when start is high and busy is low; every word produces exactly one
// result, shown for one cycle with rsp_valid high, and the receiver cannot stall it.
// From accept to rsp_valid, while no clear is pending, a word passes four front stages
// (input capture, offset, 32x32 scale multiply, grid compare with row multiply, then a
// combinational flat index add), one queue slot, the memory read, the update and the
// output register. Words stream at one per cycle while busy is low; the bin count
// memory has one read and one write port and the update forwards the previous write,
// so repeated hits on one bin need no bubble. After reset, and after every clear word,
// a sweep writes zero into all 4096 bins, one per cycle. busy stays high while any
// sweep runs, and the back end holds the queue from the time a clear is popped until
// its sweep is done, so words behind a clear wait for the sweep too. busy also rises
// when the queue plus the front pipeline hold eight words. Configuration writes are
// always taken (csr_ready is tied high) and must only be made while no word is in flight.
module histogram_2d_binner (
   input  logic                 clock,
   input  logic                 reset,
   // command
   input  logic                 start,
   output logic                 busy,
   input  h2d_pkg::h2d_req_type req_word,
   // results
   output logic                 rsp_valid,
   output h2d_pkg::h2d_rsp_type rsp_word,
   // register writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_data
);
   import h2d_pkg::*;

   h2d_cfg_type cfg_ff;

   logic              accept;
   logic              push;
   h2d_task_type      push_data;
   logic [2:0]        inflight;
   h2d_head_type      head;
   logic              pop;
   logic [QUEUE_AW:0] q_count;
   logic              sweeping;

   // busy reserves a queue slot for every word still in the front pipeline
   assign busy      = sweeping ||
                      (((QUEUE_AW+1)'(inflight) + q_count) >= (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_origin <= '0;
         cfg_ff.y_origin <= '0;
         cfg_ff.x_scale  <= 32'd65536;
         cfg_ff.y_scale  <= 32'd65536;
         cfg_ff.bins_x   <= 13'd64;
         cfg_ff.bins_y   <= 13'd64;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_X_ORIGIN: cfg_ff.x_origin <= csr_data;
            REG_Y_ORIGIN: cfg_ff.y_origin <= csr_data;
            REG_X_SCALE:  cfg_ff.x_scale  <= csr_data;
            REG_Y_SCALE:  cfg_ff.y_scale  <= csr_data;
            REG_BINS_X:   cfg_ff.bins_x   <= csr_data[12:0];
            REG_BINS_Y:   cfg_ff.bins_y   <= csr_data[12:0];
            default:      cfg_ff.bins_x   <= cfg_ff.bins_x;  // unmapped index: ignored
         endcase
      end
   end

   h2d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_word  (req_word),
      .cfg       (cfg_ff),
      .push      (push),
      .push_data (push_data),
      .inflight  (inflight)
   );

   h2d_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .count     (q_count)
   );

   h2d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .sweeping  (sweeping),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

// ===== bench/histogram_2d_binner_tb.sv =====
// Self-checking testbench for the 2-D histogram binner: directed rows, then random words.
`timescale 1ns / 100ps

module histogram_2d_binner_tb;
   import h2d_pkg::*;

   // Operation code 3 has no package name; the block must leave all state alone on it.
   localparam logic [1:0] OP_NOP = 2'd3;

   localparam int SETTLE_CYCLES   = 16;       // well past a word's path from accept to result
   localparam int CYCLE_LIMIT     = 400_000;  // reset sweep + capped clears + idle gaps, x8
   localparam int WORDS_PER_BLOCK = 50;
   localparam int RANDOM_BLOCKS   = 9;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   // One row of the directed list: either a command word or a register write.
   typedef struct {
      row_kind_type kind;
      h2d_req_type  word;
      bit           typed;      // use the hand-written result instead of the prediction
      h2d_rsp_type  want;
      logic [2:0]   reg_index;
      logic [31:0]  reg_data;
   } stim_row_type;

   // ---------------------------------------------------------------------------------
   // DUT ports; every input has a known value from time zero
   // ---------------------------------------------------------------------------------
   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        start     = 1'b0;
   logic        busy;
   h2d_req_type req_word  = '0;
   logic        rsp_valid;
   h2d_rsp_type rsp_word;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data  = '0;

   histogram_2d_binner u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------------
   // Shadow of the histogram: grid settings and every counter
   // ---------------------------------------------------------------------------------
   h2d_cfg_type grid_cfg;
   logic [31:0] bin_tally [0:MAX_BINS-1];
   logic [31:0] peak_tally;
   logic [31:0] outside_tally;

   h2d_rsp_type pending_results [$];   // results owed by the block, oldest first

   int          mismatch_count = 0;
   int          cycle_count    = 0;
   int          idle_pct       = 9;    // chance in percent that the sender skips a cycle
   int          clears_left    = 10;   // each clear costs a sweep over all 4096 bins
   h2d_req_type last_point;
   logic [11:0] last_hit = '0;

   // Bin coordinate along one axis. Offset is exact in 33 bits, product exact in 64;
   // a negative offset is off grid unless the scale is zero, which pins the bin at 0.
   function automatic bit axis_cell(input logic signed [31:0] pos,
                                    input logic signed [31:0] org,
                                    input logic [31:0] scale,
                                    output logic [63:0] bin_pos);
      longint      offs;
      logic [63:0] uoffs;
      offs    = longint'(pos) - longint'(org);
      uoffs   = offs;
      bin_pos = '0;
      if (scale == '0) return 1'b1;
      if (offs < 0) return 1'b0;
      bin_pos = (uoffs * {32'd0, scale}) >> 32;
      return 1'b1;
   endfunction

   // Applies one word to the shadow histogram and returns the result it must produce.
   function automatic h2d_rsp_type binned_result(input h2d_req_type w);
      h2d_rsp_type r;
      logic [63:0] bx, by, flat;
      bit          ok;
      r = '0;
      case (w.operation)
         OP_ACCUM: begin
            ok = w.point_defined;
            if (ok) ok = axis_cell(w.point_x, grid_cfg.x_origin, grid_cfg.x_scale, bx);
            if (ok) ok = axis_cell(w.point_y, grid_cfg.y_origin, grid_cfg.y_scale, by);
            if (ok) ok = (bx < grid_cfg.bins_x) && (by < grid_cfg.bins_y);
            if (ok) begin
               flat = by * grid_cfg.bins_x + bx;
               ok   = flat < MAX_BINS;     // flat index beyond the store counts outside
            end
            if (ok) begin
               if (bin_tally[flat[11:0]] != '1) bin_tally[flat[11:0]]++;
               if (bin_tally[flat[11:0]] > peak_tally) peak_tally = bin_tally[flat[11:0]];
               r.bin_index = flat[11:0];
               r.in_range  = 1'b1;
               r.bin_count = bin_tally[flat[11:0]];
            end else if (outside_tally != '1) begin
               outside_tally++;
            end
         end
         OP_READ: begin
            // out-of-grid reads still return the stored count
            r.bin_index = w.bin_select;
            r.bin_count = bin_tally[w.bin_select];
            r.in_range  = 32'(w.bin_select) < 32'(grid_cfg.bins_x) * 32'(grid_cfg.bins_y);
         end
         OP_CLEAR: begin
            foreach (bin_tally[i]) bin_tally[i] = '0;
            peak_tally    = '0;
            outside_tally = '0;
         end
         default: ;
      endcase
      r.peak_count    = peak_tally;
      r.outside_count = outside_tally;
      return r;
   endfunction

   // Coordinate that lands in (or next to) a chosen bin; clamps at the top of Q16.16.
   function automatic logic [31:0] aim_point(input logic signed [31:0] org,
                                             input logic [31:0] scale,
                                             input int unsigned target);
      logic [63:0] num, offs;
      longint      pos;
      if (scale == '0) return $urandom;
      num  = {target, 32'($urandom)};
      offs = num / {32'd0, scale};
      if (offs > 64'h1_0000_0000) return 32'h7FFF_FFFF;
      pos = longint'(org) + longint'(offs);
      if (pos > 64'sd2147483647) return 32'h7FFF_FFFF;
      return pos[31:0];
   endfunction

   function automatic h2d_req_type mk_word(input logic [1:0] op, input logic [31:0] x,
                                           input logic [31:0] y, input bit def,
                                           input logic [11:0] sel);
      h2d_req_type w;
      w.operation     = op;
      w.point_x       = x;
      w.point_y       = y;
      w.point_defined = def;
      w.bin_select    = sel;
      return w;
   endfunction

   function automatic h2d_rsp_type mk_rsp(input logic [11:0] idx, input bit hit,
                                          input logic [31:0] cnt, input logic [31:0] peak,
                                          input logic [31:0] outside);
      h2d_rsp_type r;
      r.bin_index     = idx;
      r.in_range      = hit;
      r.bin_count     = cnt;
      r.peak_count    = peak;
      r.outside_count = outside;
      return r;
   endfunction

   function automatic stim_row_type word_row(input h2d_req_type w, input bit typed,
                                             input h2d_rsp_type want);
      stim_row_type row;
      row           = '{kind: ROW_WORD, default: '0};
      row.word      = w;
      row.typed     = typed;
      row.want      = want;
      return row;
   endfunction

   function automatic stim_row_type csr_row(input logic [2:0] idx, input logic [31:0] data);
      stim_row_type row;
      row           = '{kind: ROW_CSR, default: '0};
      row.reg_index = idx;
      row.reg_data  = data;
      return row;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns ERROR %s: got %0h, want %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Offers one word, holding start high until the block takes it. Start is left high
   // on return; the next call or the drain decides what it does in this same step.
   task automatic send_word(input h2d_req_type w, input bit typed, input h2d_rsp_type want);
      h2d_rsp_type got;
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy !== 1'b0);
      got = binned_result(w);
      if (w.operation == OP_ACCUM && got.in_range) last_hit = got.bin_index;
      pending_results.insert(pending_results.size(), typed ? want : got);
   endtask

   // Waits until every owed result is in and the block is quiet.
   task automatic drain_block;
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         REG_X_ORIGIN: grid_cfg.x_origin = data;
         REG_Y_ORIGIN: grid_cfg.y_origin = data;
         REG_X_SCALE:  grid_cfg.x_scale  = data;
         REG_Y_SCALE:  grid_cfg.y_scale  = data;
         REG_BINS_X:   grid_cfg.bins_x   = data[12:0];
         REG_BINS_Y:   grid_cfg.bins_y   = data[12:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Grid for one random block: typical small grids, fully random settings, or extremes.
   task automatic program_block_grid(input int blk);
      logic [31:0] xo, yo, xs, ys, nx, ny;
      case (blk % 3)
         0: begin
            xo = 32'd0 - ($urandom_range(0, 32) << 16);
            yo = 32'd0 - ($urandom_range(0, 32) << 16);
            xs = 32'h0001_0000 << $urandom_range(0, 3);
            ys = 32'h0001_0000 << $urandom_range(0, 3);
            nx = $urandom_range(8, 64);
            ny = $urandom_range(8, 64);
         end
         1: begin
            // junk above bit 12 of the bin counts must be dropped
            xo = $urandom;
            yo = $urandom;
            xs = $urandom;
            ys = $urandom >> $urandom_range(0, 16);
            nx = ($urandom & 32'hFFFF_E000) | $urandom_range(1, 4096);
            ny = ($urandom & 32'hFFFF_E000) | $urandom_range(1, 4096);
         end
         default: begin
            case (blk / 3)
               0: begin   // widest row, origin at the bottom of the range
                  xo = 32'h8000_0000; yo = 32'h7FFF_FFFF;
                  xs = 32'hFFFF_FFFF; ys = 32'h0000_0000;
                  nx = 32'd4096;      ny = 32'd1;
               end
               1: begin   // single column, tallest grid
                  xo = 32'h7FFF_FFFF; yo = 32'h8000_0000;
                  xs = 32'h0000_0000; ys = 32'h0000_0001;
                  nx = 32'd1;         ny = 32'd4096;
               end
               default: begin   // largest grid, most of it past the store
                  xo = 32'h0000_0000; yo = 32'h0000_0000;
                  xs = 32'h0001_0000; ys = 32'h0001_0000;
                  nx = 32'd4096;      ny = 32'd4096;
               end
            endcase
         end
      endcase
      drain_block();
      write_reg(REG_X_ORIGIN, xo);
      write_reg(REG_Y_ORIGIN, yo);
      write_reg(REG_X_SCALE,  xs);
      write_reg(REG_Y_SCALE,  ys);
      write_reg(REG_BINS_X,   nx);
      write_reg(REG_BINS_Y,   ny);
   endtask

   // Mostly points aimed into the grid, with repeats on one bin to exercise the write
   // forwarding, reads of recent hits, rare clears, code 3 and unaimed noise.
   task automatic next_random_word(output h2d_req_type w);
      int unsigned pick, col, row_cap, col_lim;
      pick = $urandom_range(0, 99);
      w    = mk_word(OP_ACCUM, $urandom, $urandom, 1'($urandom_range(0, 1)),
                     12'($urandom));
      if (pick < 55) begin
         col_lim = (grid_cfg.bins_x > MAX_BINS) ? MAX_BINS : grid_cfg.bins_x;
         col     = $urandom_range(0, col_lim - 1);
         row_cap = (MAX_BINS - 1 - col) / grid_cfg.bins_x;
         if (row_cap > grid_cfg.bins_y - 1) row_cap = grid_cfg.bins_y - 1;
         w.point_x       = aim_point(grid_cfg.x_origin, grid_cfg.x_scale, col);
         w.point_y       = aim_point(grid_cfg.y_origin, grid_cfg.y_scale,
                                     $urandom_range(0, row_cap));
         w.point_defined = ($urandom_range(0, 9) != 0);
         last_point      = w;
      end else if (pick < 65) begin
         w = last_point;
      end else if (pick < 78) begin
         w.operation  = OP_READ;
         w.bin_select = $urandom_range(0, 1) ? last_hit : 12'($urandom);
      end else if (pick < 80 && clears_left > 0) begin
         w.operation = OP_CLEAR;
         clears_left--;
      end else if (pick < 83) begin
         w.operation = OP_NOP;
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Result checker: every strobe must match the oldest owed result, field by field
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      h2d_rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with none owed, bin_index",
                            32'(rsp_word.bin_index), '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_word.bin_index !== want.bin_index)
               report_mismatch("bin_index", 32'(rsp_word.bin_index), 32'(want.bin_index));
            if (rsp_word.in_range !== want.in_range)
               report_mismatch("in_range", 32'(rsp_word.in_range), 32'(want.in_range));
            if (rsp_word.bin_count !== want.bin_count)
               report_mismatch("bin_count", rsp_word.bin_count, want.bin_count);
            if (rsp_word.peak_count !== want.peak_count)
               report_mismatch("peak_count", rsp_word.peak_count, want.peak_count);
            if (rsp_word.outside_count !== want.outside_count)
               report_mismatch("outside_count", rsp_word.outside_count, want.outside_count);
         end
      end
   end

   // Watchdog; also catches results that never arrive.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("histogram_2d_binner: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------
   initial begin
      stim_row_type rows [$];
      h2d_req_type  w;

      // shadow reset state: 64 x 64 grid at one bin per unit from the origin
      grid_cfg      = '{x_origin: '0, y_origin: '0, x_scale: 32'h0001_0000,
                        y_scale: 32'h0001_0000, bins_x: 13'd64, bins_y: 13'd64};
      foreach (bin_tally[i]) bin_tally[i] = '0;
      peak_tally    = '0;
      outside_tally = '0;
      last_point    = mk_word(OP_ACCUM, '0, '0, 1'b1, 12'd0);

      // Directed rows. Typed results assume the reset grid and are easy to follow.
      // reads right after reset, at both ends of the store
      rows.insert(rows.size(), word_row(mk_word(OP_READ, '0, '0, 1'b0, 12'd0), 1'b1,
                  mk_rsp(12'd0, 1'b1, 32'd0, 32'd0, 32'd0)));
      rows.insert(rows.size(), word_row(mk_word(OP_READ, '0, '0, 1'b0, 12'd4095), 1'b1,
                  mk_rsp(12'd4095, 1'b1, 32'd0, 32'd0, 32'd0)));
      // same bin twice back to back
      rows.insert(rows.size(), word_row(mk_word(OP_ACCUM, '0, '0, 1'b1, 12'd0), 1'b1,
                  mk_rsp(12'd0, 1'b1, 32'd1, 32'd1, 32'd0)));
      rows.insert(rows.size(), word_row(mk_word(OP_ACCUM, '0, '0, 1'b1, 12'd0), 1'b1,
                  mk_rsp(12'd0, 1'b1, 32'd2, 32'd2, 32'd0)));
      // undefined point, then negative offset
      rows.insert(rows.size(), word_row(mk_word(OP_ACCUM, '0, '0, 1'b0, 12'd0), 1'b1,
                  mk_rsp(12'd0, 1'b0, 32'd0, 32'd2, 32'd1)));
      rows.insert(rows.size(), word_row(mk_word(OP_ACCUM, 32'hFFFF_FFFF, '0, 1'b1, 12'd0),
                  1'b1, mk_rsp(12'd0, 1'b0, 32'd0, 32'd2, 32'd2)));
      // last bin of the grid, then just past the right edge
      rows.insert(rows.size(), word_row(mk_word(OP_ACCUM, 32'h003F_FFFF, 32'h003F_FFFF,
                  1'b1, 12'd0), 1'b1, mk_rsp(12'd4095, 1'b1, 32'd1, 32'd2, 32'd2)));
      rows.insert(rows.size(), word_row(mk_word(OP_ACCUM, 32'h0040_0000, '0, 1'b1, 12'd0),
                  1'b1, mk_rsp(12'd0, 1'b0, 32'd0, 32'd2, 32'd3)));
      // coordinate extremes
      rows.insert(rows.size(), word_row(mk_word(OP_ACCUM, 32'h7FFF_FFFF, 32'h8000_0000,
                  1'b1, 12'd0), 1'b1, mk_rsp(12'd0, 1'b0, 32'd0, 32'd2, 32'd4)));
      rows.insert(rows.size(), word_row(mk_word(OP_ACCUM, 32'h8000_0000, 32'h7FFF_FFFF,
                  1'b1, 12'd0), 1'b1, mk_rsp(12'd0, 1'b0, 32'd0, 32'd2, 32'd5)));
      // code 3 leaves everything alone
      rows.insert(rows.size(), word_row(mk_word(OP_NOP, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  1'b1, 12'd4095), 1'b1, mk_rsp(12'd0, 1'b0, 32'd0, 32'd2, 32'd5)));
      rows.insert(rows.size(), word_row(mk_word(OP_READ, '0, '0, 1'b0, 12'd0), 1'b1,
                  mk_rsp(12'd0, 1'b1, 32'd2, 32'd2, 32'd5)));
      // clear wipes counts, peak and outside total
      rows.insert(rows.size(), word_row(mk_word(OP_CLEAR, '0, '0, 1'b0, 12'd0), 1'b1,
                  mk_rsp(12'd0, 1'b0, 32'd0, 32'd0, 32'd0)));
      rows.insert(rows.size(), word_row(mk_word(OP_READ, '0, '0, 1'b0, 12'd0), 1'b1,
                  mk_rsp(12'd0, 1'b1, 32'd0, 32'd0, 32'd0)));
      rows.insert(rows.size(), word_row(mk_word(OP_ACCUM, 32'h0001_8000, 32'h0002_0000,
                  1'b1, 12'd0), 1'b1, mk_rsp(12'd129, 1'b1, 32'd1, 32'd1, 32'd0)));
      // wide grid: flat index beyond the store counts outside
      rows.insert(rows.size(), csr_row(REG_BINS_X, 32'd4096));
      rows.insert(rows.size(), csr_row(REG_BINS_Y, 32'd2));
      rows.insert(rows.size(), word_row(mk_word(OP_ACCUM, 32'h000A_0000, 32'h0001_0000,
                  1'b1, 12'd0), 1'b0, '0));
      rows.insert(rows.size(), word_row(mk_word(OP_READ, '0, '0, 1'b0, 12'd4095), 1'b0,
                  '0));
      rows.insert(rows.size(), word_row(mk_word(OP_ACCUM, 32'h0FFF_8000, '0, 1'b1, 12'd0),
                  1'b0, '0));
      // zero bins: nothing lands, reads report out of grid but return the count
      rows.insert(rows.size(), csr_row(REG_BINS_X, 32'd0));
      rows.insert(rows.size(), word_row(mk_word(OP_ACCUM, '0, '0, 1'b1, 12'd0), 1'b0, '0));
      rows.insert(rows.size(), word_row(mk_word(OP_READ, '0, '0, 1'b0, 12'd129), 1'b0,
                  '0));
      // zero x scale with negative offset, full y scale from the bottom of the range
      rows.insert(rows.size(), csr_row(REG_BINS_X, 32'd8));
      rows.insert(rows.size(), csr_row(REG_BINS_Y, 32'd8));
      rows.insert(rows.size(), csr_row(REG_X_ORIGIN, 32'h0010_0000));
      rows.insert(rows.size(), csr_row(REG_X_SCALE, 32'h0000_0000));
      rows.insert(rows.size(), csr_row(REG_Y_ORIGIN, 32'h8000_0000));
      rows.insert(rows.size(), csr_row(REG_Y_SCALE, 32'hFFFF_FFFF));
      rows.insert(rows.size(), word_row(mk_word(OP_ACCUM, 32'hFFFB_0000, 32'h8000_0003,
                  1'b1, 12'd0), 1'b0, '0));
      rows.insert(rows.size(), word_row(mk_word(OP_ACCUM, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  1'b1, 12'd0), 1'b0, '0));
      rows.insert(rows.size(), word_row(mk_word(OP_READ, '0, '0, 1'b0, 12'd100), 1'b0,
                  '0));
      rows.insert(rows.size(), word_row(mk_word(OP_ACCUM, '0, 32'h8000_0008, 1'b1, 12'd0),
                  1'b0, '0));
      rows.insert(rows.size(), word_row(mk_word(OP_ACCUM, '0, 32'h8000_0008, 1'b0, 12'd0),
                  1'b0, '0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CSR) begin
            drain_block();
            write_reg(rows[i].reg_index, rows[i].reg_data);
         end else begin
            send_word(rows[i].word, rows[i].typed, rows[i].want);
         end
      end

      // Random part: three idle patterns, three grids each.
      for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
         idle_pct = (blk < 3) ? 9 : (blk < 6) ? 88 : 0;
         program_block_grid(blk);
         repeat (WORDS_PER_BLOCK) begin
            next_random_word(w);
            send_word(w, 1'b0, '0);
         end
      end

      drain_block();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("histogram_2d_binner: match");
      end else begin
         $display("histogram_2d_binner: mismatch");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/h2d_pkg.sv
hdl/h2d_front.sv
hdl/h2d_queue.sv
hdl/h2d_back.sv
hdl/histogram_2d_binner.sv
bench/histogram_2d_binner_tb.sv
